/* hdl/gdd_pkg.sv */
// ----------------------------------------------------------------------------
// gdd_pkg
// shared types, constants and calendar helpers for the date distance block
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int SERIAL_W = 23;          // internal day serial, holds out of range years too
  localparam int DIST_W   = 22;          // distance field of the result

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [2:0]  WEEKDAY_MAX = 3'd6;
  localparam logic [8:0]  DAYS_YEAR = 9'd365;
  localparam logic [6:0]  CENTURY   = 7'd100;
  localparam logic [13:0] CENTURY_LAST = 14'd99;

  // x / 100 as (x * 5243) >> 19, exact for every 14-bit x
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // req_type bit that selects the nth-weekday form of each date
  localparam int FORM_A_BIT = 1;
  localparam int FORM_B_BIT = 0;

  typedef struct packed {
    logic                ok;
    logic [SERIAL_W-1:0] serial;
  } gdd_date_t;

  typedef struct packed {
    logic              invalid;
    logic [DIST_W-1:0] distance;
  } gdd_res_t;

  // days before the month in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // month length in a common year
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] d;
    case (month)
      4'd2:                     d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:       d = 5'd31;
      default:                  d = 5'd0;
    endcase
    return d;
  endfunction

  // modulo 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [SERIAL_W-1:0] x);
    logic [23:0] xe;
    logic [5:0]  s;
    logic [3:0]  t;
    logic [3:0]  u;
    xe = 24'(x);
    s  = 6'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(xe[3*i +: 3]);
    end
    t = 4'(s[5:3]) + 4'(s[2:0]);
    u = 4'(t[3]) + 4'(t[2:0]);
    if (u >= 4'd7) begin
      u = u - 4'd7;
    end
    return u[2:0];
  endfunction

endpackage

/* hdl/gdd_serial.sv */
// ----------------------------------------------------------------------------
// gdd_serial
// five stage pipeline turning one date into its day serial and a validity flag
// ----------------------------------------------------------------------------
module gdd_serial
  import gdd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic        nth_form,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [2:0]  week,
  input  logic [2:0]  weekday,
  output gdd_date_t   date
);

  // stage 1: range checks, y-1 and its century count
  logic [13:0] s1_y1_r;
  logic [7:0]  s1_q_r;
  logic        s1_bad_r;
  logic        s1_nth_r;
  logic [3:0]  s1_month_r;
  logic [4:0]  s1_day_r;
  logic [2:0]  s1_week_r;
  logic [2:0]  s1_wd_r;

  logic [13:0] y1_nxt;
  logic [26:0] prod_nxt;
  logic        bad1_nxt;

  always_comb begin
    y1_nxt   = year - 14'd1;
    prod_nxt = 27'(y1_nxt) * 27'(RECIP_100);
    bad1_nxt = (year == 14'd0) || (year > YEAR_MAX) ||
               (month == 4'd0) || (month > MONTH_MAX) ||
               (nth_form && ((weekday > WEEKDAY_MAX) || (week == 3'd0)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y1_r    <= y1_nxt;
      s1_q_r     <= prod_nxt[RECIP_SHIFT +: 8];
      s1_bad_r   <= bad1_nxt;
      s1_nth_r   <= nth_form;
      s1_month_r <= month;
      s1_day_r   <= day;
      s1_week_r  <= week;
      s1_wd_r    <= weekday;
    end
  end

  // stage 2: days of earlier years and the leap flag
  logic [SERIAL_W-1:0] s2_start_y_r;
  logic                s2_leap_r;
  logic                s2_bad_r;
  logic                s2_nth_r;
  logic [3:0]          s2_month_r;
  logic [4:0]          s2_day_r;
  logic [2:0]          s2_week_r;
  logic [2:0]          s2_wd_r;

  logic [13:0]         r100_nxt;
  logic                leap_nxt;
  logic [SERIAL_W-1:0] start_y_nxt;

  always_comb begin
    r100_nxt = s1_y1_r - (14'(s1_q_r) * 14'(CENTURY));
    // year % 4 == 0 is y1 % 4 == 3; a century year is y1 % 100 == 99
    leap_nxt = (s1_y1_r[1:0] == 2'd3) &&
               ((r100_nxt != CENTURY_LAST) || (s1_q_r[1:0] == 2'd3));
    start_y_nxt = SERIAL_W'(s1_y1_r) * SERIAL_W'(DAYS_YEAR)
                + SERIAL_W'(s1_y1_r[13:2])
                - SERIAL_W'(s1_q_r)
                + SERIAL_W'(s1_q_r[7:2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_start_y_r <= start_y_nxt;
      s2_leap_r    <= leap_nxt;
      s2_bad_r     <= s1_bad_r;
      s2_nth_r     <= s1_nth_r;
      s2_month_r   <= s1_month_r;
      s2_day_r     <= s1_day_r;
      s2_week_r    <= s1_week_r;
      s2_wd_r      <= s1_wd_r;
    end
  end

  // stage 3: first day of the month and month length
  logic [SERIAL_W-1:0] s3_start_r;
  logic [4:0]          s3_len_r;
  logic                s3_bad_r;
  logic                s3_nth_r;
  logic [4:0]          s3_day_r;
  logic [2:0]          s3_week_r;
  logic [2:0]          s3_wd_r;

  logic [SERIAL_W-1:0] start_nxt;
  logic [4:0]          len_nxt;
  logic                bad3_nxt;

  always_comb begin
    start_nxt = s2_start_y_r + SERIAL_W'(days_before_month(s2_month_r))
              + SERIAL_W'(s2_leap_r && (s2_month_r > MONTH_FEB));
    len_nxt   = month_days(s2_month_r) + 5'(s2_leap_r && (s2_month_r == MONTH_FEB));
    bad3_nxt  = s2_bad_r ||
                (!s2_nth_r && ((s2_day_r == 5'd0) || (s2_day_r > len_nxt)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_start_r <= start_nxt;
      s3_len_r   <= len_nxt;
      s3_bad_r   <= bad3_nxt;
      s3_nth_r   <= s2_nth_r;
      s3_day_r   <= s2_day_r;
      s3_week_r  <= s2_week_r;
      s3_wd_r    <= s2_wd_r;
    end
  end

  // stage 4: weekday of the first of the month and offset to the wanted weekday
  logic [SERIAL_W-1:0] s4_start_r;
  logic [4:0]          s4_len_r;
  logic                s4_bad_r;
  logic                s4_nth_r;
  logic [4:0]          s4_day_r;
  logic [2:0]          s4_week_r;
  logic [2:0]          s4_off_r;

  logic [2:0] first_wd_nxt;
  logic [3:0] off_sum_nxt;
  logic [3:0] off_nxt;

  always_comb begin
    first_wd_nxt = mod7(s3_start_r);
    off_sum_nxt  = 4'(s3_wd_r) + 4'd7 - 4'(first_wd_nxt);
    off_nxt      = (off_sum_nxt >= 4'd7) ? (off_sum_nxt - 4'd7) : off_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_start_r <= s3_start_r;
      s4_len_r   <= s3_len_r;
      s4_bad_r   <= s3_bad_r;
      s4_nth_r   <= s3_nth_r;
      s4_day_r   <= s3_day_r;
      s4_week_r  <= s3_week_r;
      s4_off_r   <= off_nxt[2:0];
    end
  end

  // stage 5: final serial
  gdd_date_t  s5_date_r;
  gdd_date_t  date_nxt;
  logic [5:0] pos_nxt;

  always_comb begin
    pos_nxt = 6'(s4_off_r) + 6'(s4_week_r - 3'd1) * 6'd7;
    if (s4_nth_r) begin
      date_nxt.serial = s4_start_r + SERIAL_W'(pos_nxt);
      date_nxt.ok     = !s4_bad_r && (pos_nxt < 6'(s4_len_r));
    end else begin
      date_nxt.serial = s4_start_r + SERIAL_W'(s4_day_r) - SERIAL_W'(1);
      date_nxt.ok     = !s4_bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_date_r <= date_nxt;
    end
  end

  assign date = s5_date_r;

endmodule

/* hdl/gdd_out_buf.sv */
// ----------------------------------------------------------------------------
// gdd_out_buf
// output register with a skid stage, so the pipeline stall is registered
// ----------------------------------------------------------------------------
module gdd_out_buf
  import gdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     p_valid,
  input  gdd_res_t p_res,
  output logic     hold,
  output logic     out_valid,
  input  logic     out_ready,
  output gdd_res_t out_res
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  gdd_res_t out_res_r, out_res_nxt;
  gdd_res_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // pipeline frozen, drain the skid word once the sink takes the current one
      if (out_ready) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_nxt = p_valid;
      out_res_nxt   = p_res;
    end else if (p_valid) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = p_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign hold      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* hdl/gregorian_date_distance.sv */
// ----------------------------------------------------------------------------
// gregorian_date_distance
// days between two proleptic gregorian dates, each given as y-m-d or nth weekday
// ----------------------------------------------------------------------------
// usage
//   in_*  : one word per date pair; in_tuser carries req_type, bit 1 puts the
//           first date in nth-weekday form, bit 0 the second one
//   out_* : one word per input word, same order; out_tuser flags a pair in
//           which either date does not exist, distance is then zero
//   path: an accepted word reaches out_tvalid through the five serial
//           stages, the difference stage and the output register
//   throughput: one word per cycle while the sink keeps out_tready high
//   stall: while the output register is held, the next finished word parks
//           in a skid stage; in_tready drops from the following cycle and
//           the whole pipeline freezes until the skid word drains, nothing
//           is dropped
//   reset: rst_n low clears every valid bit, those of both output stages too;
//           in_tready is high straight after reset
//   no configuration registers and no state kept between words
// ----------------------------------------------------------------------------
module gregorian_date_distance
  import gdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // year_a, month_a, day_a, week_a, weekday_a, year_b, month_b, day_b,
  // week_b, weekday_b, zero pad
  input  logic [63:0] in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // distance, zero pad
  output logic [23:0] out_tdata,
  // invalid
  output logic        out_tuser
);

  // serial stages plus the difference stage
  localparam int PIPE_DEPTH = 6;

  logic en;
  logic hold;

  // pipeline advances while the skid stage is empty
  assign en        = !hold;
  assign in_tready = en;

  // valid bits travelling beside the data
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // per date serial pipelines
  gdd_date_t date_a;
  gdd_date_t date_b;

  gdd_serial u_serial_a (
    .clk      (clk),
    .en       (en),
    .nth_form (in_tuser[FORM_A_BIT]),
    .year     (in_tdata[13:0]),
    .month    (in_tdata[17:14]),
    .day      (in_tdata[22:18]),
    .week     (in_tdata[25:23]),
    .weekday  (in_tdata[28:26]),
    .date     (date_a)
  );

  gdd_serial u_serial_b (
    .clk      (clk),
    .en       (en),
    .nth_form (in_tuser[FORM_B_BIT]),
    .year     (in_tdata[42:29]),
    .month    (in_tdata[46:43]),
    .day      (in_tdata[51:47]),
    .week     (in_tdata[54:52]),
    .weekday  (in_tdata[57:55]),
    .date     (date_b)
  );

  // difference stage: absolute difference, forced to zero on an invalid pair
  gdd_res_t res_r, res_nxt;

  always_comb begin
    res_nxt.invalid = !(date_a.ok && date_b.ok);
    if (res_nxt.invalid) begin
      res_nxt.distance = '0;
    end else if (date_a.serial >= date_b.serial) begin
      res_nxt.distance = DIST_W'(date_a.serial - date_b.serial);
    end else begin
      res_nxt.distance = DIST_W'(date_b.serial - date_a.serial);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // output register and skid stage
  gdd_res_t out_res;

  gdd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (vld_r[PIPE_DEPTH-1] && en),
    .p_res     (res_r),
    .hold      (hold),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.distance};
  assign out_tuser = out_res.invalid;

  // a parked skid word always sits behind a valid output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> out_tvalid)
    else $error("skid stage full while output register empty");

  // a finished word meeting a stalled output must land in the skid stage
  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[PIPE_DEPTH-1] && out_tvalid && !out_tready) |=> hold)
    else $error("word lost on output stall");

  // invalid pairs carry a zero distance
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 24'd0))
    else $error("invalid pair with nonzero distance");

  // a valid distance never exceeds the span of years 1 to 9999
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata <= 24'd3652058))
    else $error("distance out of range");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for gregorian_date_distance: date pairs in all four
// forms go in, each result word is checked against a day serial predictor
// ----------------------------------------------------------------------------
module tb
  import gdd_pkg::*;
;

  // req_type codes: bit 1 puts the first date in nth-weekday form, bit 0 the second
  localparam logic [1:0] REQ_YMD_YMD = 2'd0;
  localparam logic [1:0] REQ_YMD_NTH = 2'd1;
  localparam logic [1:0] REQ_NTH_YMD = 2'd2;
  localparam logic [1:0] REQ_NTH_NTH = 2'd3;

  localparam int MAX_IDLE     = 11;   // longest gap or stall drawn per word
  localparam int SETTLE_WAIT  = 20;   // pipeline is 7 deep, plus the skid stage
  localparam int REPORT_LIMIT = 30;

  // one date, fields listed from the highest bit down, year at the lowest bits
  typedef struct packed {
    logic [2:0]  weekday;
    logic [2:0]  week;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  typedef struct {
    bit          ok;
    int unsigned serial;
  } day_serial_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  gdd_res_t expected_distances[$];

  int pairs_sent;
  int results_seen;
  int invalid_seen;
  int fail_count;
  bit src_idle_on;
  bit snk_idle_on;
  int sink_hold_cycles;

  gregorian_date_distance DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------------
  // calendar predictor
  // ------------------------------------------------------------------------

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, bit leap);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // day serial counted from 0001-01-01, a monday
  function automatic day_serial_t date_to_serial(bit nth_form, date_t d);
    day_serial_t r;
    int unsigned y1;
    int unsigned start;
    int unsigned len;
    int unsigned first_wd;
    int unsigned pos;
    bit          leap;
    r.ok     = 1'b0;
    r.serial = 0;
    if (d.year == 0 || d.year > YEAR_MAX || d.month == 0 || d.month > MONTH_MAX) begin
      return r;
    end
    leap  = is_leap_year(d.year);
    y1    = d.year - 1;
    start = y1 * 365 + y1 / 4 - y1 / 100 + y1 / 400;
    for (int m = 1; m < d.month; m++) begin
      start += month_length(m, leap);
    end
    len = month_length(d.month, leap);
    if (!nth_form) begin
      if (d.day == 0 || d.day > len) begin
        return r;
      end
      r.serial = start + d.day - 1;
    end else begin
      if (d.weekday > WEEKDAY_MAX || d.week == 0) begin
        return r;
      end
      // first matching weekday of the month, then whole weeks on
      first_wd = start % 7;
      pos      = (d.weekday + 7 - first_wd) % 7 + (d.week - 1) * 7;
      if (pos >= len) begin
        return r;
      end
      r.serial = start + pos;
    end
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic gdd_res_t predict_distance(logic [1:0] req, date_t a, date_t b);
    gdd_res_t    res;
    day_serial_t sa;
    day_serial_t sb;
    sa = date_to_serial(req[FORM_A_BIT], a);
    sb = date_to_serial(req[FORM_B_BIT], b);
    res.invalid  = 1'b0;
    res.distance = '0;
    if (sa.ok && sb.ok) begin
      res.distance = DIST_W'((sa.serial >= sb.serial) ? sa.serial - sb.serial
                                                       : sb.serial - sa.serial);
    end else begin
      res.invalid = 1'b1;
    end
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // unused week/weekday set to all ones, the block must ignore them
  function automatic date_t ymd(int unsigned y, int unsigned m, int unsigned d);
    date_t r;
    r.year    = 14'(y);
    r.month   = 4'(m);
    r.day     = 5'(d);
    r.week    = '1;
    r.weekday = '1;
    return r;
  endfunction

  // unused day set to all ones
  function automatic date_t nth(int unsigned y, int unsigned m, int unsigned w,
                                int unsigned wd);
    date_t r;
    r.year    = 14'(y);
    r.month   = 4'(m);
    r.day     = '1;
    r.week    = 3'(w);
    r.weekday = 3'(wd);
    return r;
  endfunction

  // mostly real dates, weighted toward the month ends and year extremes, some broken fields
  function automatic date_t random_date();
    date_t       d;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      d.year = 14'($urandom_range(1, 5));
    end else if (pick < 10) begin
      d.year = 14'($urandom_range(9995, 9999));
    end else begin
      d.year = 14'($urandom_range(1, 9999));
    end
    d.month   = 4'($urandom_range(1, 12));
    len       = month_length(d.month, is_leap_year(d.year));
    d.day     = ($urandom_range(0, 3) == 0) ? 5'(len - 1 + $urandom_range(0, 2))
                                            : 5'($urandom_range(1, len));
    d.week    = 3'($urandom_range(1, 5));
    d.weekday = 3'($urandom_range(0, 6));
    // scramble one field over its whole width now and then
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       d.year    = 14'($urandom_range(0, 16383));
        1:       d.month   = 4'($urandom_range(0, 15));
        2:       d.day     = 5'($urandom_range(0, 31));
        3:       d.week    = 3'($urandom_range(0, 7));
        default: d.weekday = 3'($urandom_range(0, 7));
      endcase
    end
    return d;
  endfunction

  function automatic date_t noise_date();
    date_t d;
    d.year    = 14'($urandom_range(0, 16383));
    d.month   = 4'($urandom_range(0, 15));
    d.day     = 5'($urandom_range(0, 31));
    d.week    = 3'($urandom_range(0, 7));
    d.weekday = 3'($urandom_range(0, 7));
    return d;
  endfunction

  // ------------------------------------------------------------------------
  // sender: one word per call, entered and left at a rising edge
  // ------------------------------------------------------------------------
  task automatic send_pair(logic [1:0] req, date_t a, date_t b);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {6'd0, b, a};
    // in_tready only moves on a rising edge, so the falling edge shows the
    // value that decides the next edge
    do @(negedge clk); while (!in_tready);
    expected_distances.push_back(predict_distance(req, a, b));
    pairs_sent++;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // sink: stall per word, or one long hold when a test asks for it
  // ------------------------------------------------------------------------
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  // ------------------------------------------------------------------------
  // result checker
  // ------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    if (fail_count < REPORT_LIMIT) begin
      $display("mismatch on result %0d, %0s: got %0d, want %0d",
               results_seen, what, got, want);
    end
    fail_count++;
  endtask

  // outputs and out_tready are steady on the falling edge, the word moves
  // on the following rising edge
  always @(negedge clk) begin
    gdd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_distances.size() == 0) begin
        report_mismatch("word with nothing pending", out_tdata, 0);
      end else begin
        want = expected_distances.pop_front();
        if (out_tdata[DIST_W-1:0] !== want.distance) begin
          report_mismatch("distance", out_tdata[DIST_W-1:0], want.distance);
        end
        if (out_tuser !== want.invalid) begin
          report_mismatch("invalid flag", out_tuser, want.invalid);
        end
        if (out_tdata[23:DIST_W] !== '0) begin
          report_mismatch("tdata pad bits", out_tdata[23:DIST_W], 0);
        end
      end
      if (out_tuser === 1'b1) begin
        invalid_seen++;
      end
      results_seen++;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // field extremes, every form and each calendar corner case
  task automatic test_directed();
    // widest span, and the same date twice
    send_pair(REQ_YMD_YMD, ymd(1, 1, 1), ymd(9999, 12, 31));
    send_pair(REQ_YMD_YMD, ymd(2024, 2, 29), ymd(2024, 2, 29));
    // century rule: 1900 is common, 2000 is leap
    send_pair(REQ_YMD_YMD, ymd(1900, 2, 29), ymd(2000, 1, 1));
    send_pair(REQ_YMD_YMD, ymd(2000, 2, 29), ymd(1900, 3, 1));
    // day past the month end, day zero, highest day code
    send_pair(REQ_YMD_YMD, ymd(2023, 4, 31), ymd(2023, 5, 1));
    send_pair(REQ_YMD_YMD, ymd(2023, 1, 0), ymd(2023, 1, 1));
    send_pair(REQ_YMD_YMD, ymd(2023, 1, 31), ymd(2023, 3, 31));
    // month out of range, low and high
    send_pair(REQ_YMD_YMD, ymd(2023, 0, 1), ymd(2023, 1, 1));
    send_pair(REQ_YMD_YMD, ymd(2023, 6, 1), ymd(2023, 13, 1));
    send_pair(REQ_NTH_NTH, nth(2023, 15, 1, 0), nth(2023, 1, 1, 0));
    // year out of range: zero, just past the top, all ones
    send_pair(REQ_YMD_YMD, ymd(0, 1, 1), ymd(1, 1, 1));
    send_pair(REQ_YMD_YMD, ymd(9999, 12, 31), ymd(10000, 1, 1));
    send_pair(REQ_YMD_NTH, ymd(16383, 12, 31), nth(16383, 1, 1, 0));
    // fifth thursday of february only exists in a leap year
    send_pair(REQ_YMD_NTH, ymd(2024, 1, 1), nth(2024, 2, 5, 3));
    send_pair(REQ_YMD_NTH, ymd(2023, 1, 1), nth(2023, 2, 5, 3));
    // first monday of year one is day zero
    send_pair(REQ_NTH_YMD, nth(1, 1, 1, 0), ymd(1, 1, 1));
    // week zero, weekday code seven, occurrence seven
    send_pair(REQ_NTH_YMD, nth(2023, 3, 0, 2), ymd(2023, 3, 1));
    send_pair(REQ_NTH_YMD, nth(2023, 3, 2, 7), ymd(2023, 3, 1));
    send_pair(REQ_NTH_NTH, nth(2023, 4, 7, 0), nth(2023, 4, 1, 0));
    // sundays and fifth weeks at both ends of the calendar, and in february of two leap centuries
    send_pair(REQ_NTH_YMD, nth(9999, 12, 1, 6), ymd(1, 1, 7));
    send_pair(REQ_NTH_NTH, nth(9999, 12, 5, 0), nth(1, 1, 5, 6));
    send_pair(REQ_NTH_NTH, nth(1600, 2, 4, 6), nth(2400, 2, 4, 6));
  endtask

  // mixed forms with random content, a slice of pure noise
  task automatic test_random_pairs(int count);
    logic [1:0] req;
    date_t      a;
    date_t      b;
    for (int i = 0; i < count; i++) begin
      req = 2'($urandom_range(REQ_YMD_YMD, REQ_NTH_NTH));
      if ($urandom_range(0, 19) == 0) begin
        a = noise_date();
        b = noise_date();
      end else begin
        a = random_date();
        b = random_date();
      end
      send_pair(req, a, b);
    end
  endtask

  // sink holds off long enough that the pipeline and skid stage fill and
  // in_tready drops while the source keeps offering words
  task automatic test_sink_backpressure();
    src_idle_on      = 1'b0;
    sink_hold_cycles = 300;
    test_random_pairs(48);
    src_idle_on = 1'b1;
  endtask

  // both sides at full rate
  task automatic test_back_to_back(int count);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_random_pairs(count);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    in_tuser         <= REQ_YMD_YMD;
    pairs_sent       = 0;
    results_seen     = 0;
    invalid_seen     = 0;
    fail_count       = 0;
    src_idle_on      = 1'b1;
    snk_idle_on      = 1'b1;
    sink_hold_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_random_pairs(500);
    drain_results();
    test_sink_backpressure();
    drain_results();
    test_back_to_back(300);
    drain_results();
    test_random_pairs(450);
    drain_results();

    // nothing further may come out once the pipeline has emptied
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("checked %0d date pairs against %0d result words, %0d of them flagged invalid",
             pairs_sent, results_seen, invalid_seen);
    $display("covered all four date forms, long sink hold-off and full-rate streaming");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_distances.size());
    $display("status: fail");
    $finish;
  end

endmodule
